/* rtl/lmmp_pkg.sv */
// ----------------------------------------------------------------------------
// lmmp_pkg: shared types and constants of the landmark map
// Beat formats, status codes, sequencer states and distance unit operations.
// ----------------------------------------------------------------------------
`default_nettype none

package lmmp_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int COORD_W      = 24;
    localparam int DIST_W       = 16;
    localparam int MAG_W        = COORD_W + 1;
    localparam int PROD_W       = 2 * MAG_W;
    localparam int OCC_W        = 6;

    localparam logic [DIST_W-1:0] MERGE_RST = 16'd128;
    localparam logic [DIST_W-1:0] KEEP_RST  = 16'd2560;

    typedef enum logic [1:0] {
        CFG_MERGE = 2'd0,
        CFG_KEEP  = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_DUP    = 3'd1,
        ST_FULL   = 3'd2,
        ST_LISTED = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        DOP_X   = 2'd0,
        DOP_Y   = 2'd1,
        DOP_LIM = 2'd2
    } t_dist_op;

    typedef enum logic [3:0] {
        S_IDLE, S_LIM, S_LIMW, S_RD, S_SQX, S_SQY, S_CMP,
        S_OBS_END, S_FEND, S_EMIT, S_LRD, S_LEMIT
    } t_state;

    typedef struct packed {
        logic                       cmd;
        logic                       side;
        logic signed [COORD_W-1:0]  obs_x;
        logic signed [COORD_W-1:0]  obs_y;
        logic signed [COORD_W-1:0]  vehicle_x;
        logic signed [COORD_W-1:0]  vehicle_y;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]                 status;
        logic                       entry_side;
        logic signed [COORD_W-1:0]  entry_x;
        logic signed [COORD_W-1:0]  entry_y;
        logic [OCC_W-1:0]           occupancy;
        logic                       last;
    } t_out_beat;

    typedef struct packed {
        logic                       side;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_entry;

    // control from the sequencer to the distance unit
    typedef struct packed {
        t_dist_op                   op;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic [DIST_W-1:0]          lim;
    } t_dist_ctl;

endpackage

`default_nettype wire

/* rtl/lmmp_store.sv */
// ----------------------------------------------------------------------------
// lmmp_store: landmark table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lmmp_store #(
    parameter int CAPACITY = lmmp_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  wire [AW-1:0]         i_wr_addr,
    input  lmmp_pkg::t_entry     i_wr_data,
    input  wire                  i_rd_en,
    input  wire [AW-1:0]         i_rd_addr,
    output lmmp_pkg::t_entry     o_rd_data
);
    import lmmp_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

/* rtl/lmmp_dist.sv */
// ----------------------------------------------------------------------------
// lmmp_dist: shared squaring unit
// Squares one coordinate difference or one radius per cycle, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lmmp_dist (
    input  wire                              i_clk,
    input  lmmp_pkg::t_dist_ctl              i_ctl,
    output logic [lmmp_pkg::PROD_W-1:0]      o_prod
);
    import lmmp_pkg::*;

    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       r_prod;

    // operand select and magnitude
    always_comb begin
        case (i_ctl.op)
            DOP_X:   diff = MAG_W'(i_ctl.ax) - MAG_W'(i_ctl.bx);
            DOP_Y:   diff = MAG_W'(i_ctl.ay) - MAG_W'(i_ctl.by);
            DOP_LIM: diff = signed'({{(MAG_W-DIST_W){1'b0}}, i_ctl.lim});
            default: diff = '0;
        endcase
        mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end

    // one multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= mag * mag;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* rtl/landmark_map_merge_prune.sv */
// ----------------------------------------------------------------------------
// landmark_map_merge_prune: distance-gated landmark map with pruning
//
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one command beat
// at a time. An observe beat is checked against the stored landmarks of the
// same side until the first match and answered by one result beat: added, duplicate or dropped.
// A frame-end beat prunes every landmark beyond keep distance of the vehicle,
// compacting the table in order, then lists each survivor as one result beat
// with last set on the final one, or gives one "table empty" beat.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes merge distance
// (index 0) and keep distance (index 1); other indexes are ignored.
// Sequence: each stored entry passes through the shared squaring unit as
// read, square x, square y and compare, after a setup that squares the
// radius and before a finish step; a frame end then reads and lists each
// survivor. The table memory read port and the single multiplier set this
// order. Input is not ready until the sequencer is idle again.
// Reset empties the table and restores the default radii; the memory needs
// no clearing. The one-beat output register holds while the receiver stalls
// and the sequencer waits until it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module landmark_map_merge_prune #(
    parameter int CAPACITY = lmmp_pkg::CAPACITY_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  lmmp_pkg::t_in_beat   i_in,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output lmmp_pkg::t_out_beat  o_out,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [1:0]            i_cfg_index,
    input  wire [15:0]           i_cfg_data
);
    import lmmp_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    t_in_beat           r_in;
    logic [CW-1:0]      r_i, r_n, r_count;
    logic [PROD_W-1:0]  r_lim, r_sqx;
    logic [DIST_W-1:0]  r_merge, r_keep;
    t_status            r_status;
    t_out_beat          r_out;
    logic               r_out_valid;

    t_entry             rd_data, wr_data;
    logic               rd_en, wr_en, push, slot_free, hit;
    logic [AW-1:0]      rd_addr, wr_addr;
    t_dist_ctl          dist_ctl;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W:0]    sum;
    t_out_beat          push_beat;

    lmmp_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lmmp_dist u_dist (
        .i_clk  (i_clk),
        .i_ctl  (dist_ctl),
        .o_prod (prod)
    );

    assign slot_free = !r_out_valid || i_out_ready;
    assign sum       = {1'b0, r_sqx} + {1'b0, prod};
    assign hit       = r_in.cmd ? ({1'b0, r_lim} >= sum)
                                : ((rd_data.side == r_in.side) && (sum < {1'b0, r_lim}));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_LIM;
            S_LIM:     n_state = S_LIMW;
            S_LIMW: begin
                if (r_count == '0) n_state = r_in.cmd ? S_FEND : S_OBS_END;
                else               n_state = S_RD;
            end
            S_RD:      n_state = S_SQX;
            S_SQX:     n_state = S_SQY;
            S_SQY:     n_state = S_CMP;
            S_CMP: begin
                if (!r_in.cmd && hit)       n_state = S_EMIT;
                else if (r_i + 1'b1 == r_count) n_state = r_in.cmd ? S_FEND : S_OBS_END;
                else                        n_state = S_RD;
            end
            S_OBS_END: n_state = S_EMIT;
            S_FEND:    n_state = (r_n == '0) ? S_EMIT : S_LRD;
            S_EMIT:    if (slot_free) n_state = S_IDLE;
            S_LRD:     n_state = S_LEMIT;
            S_LEMIT: begin
                if (slot_free) n_state = (r_i + 1'b1 == r_count) ? S_IDLE : S_LRD;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = r_i[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_n[AW-1:0];
        wr_data     = rd_data;
        push        = 1'b0;
        push_beat   = '0;
        dist_ctl.op = DOP_X;
        dist_ctl.ax = r_in.cmd ? r_in.vehicle_x : r_in.obs_x;
        dist_ctl.ay = r_in.cmd ? r_in.vehicle_y : r_in.obs_y;
        dist_ctl.bx = rd_data.x;
        dist_ctl.by = rd_data.y;
        dist_ctl.lim = r_in.cmd ? r_keep : r_merge;
        case (r_state)
            S_LIM:  dist_ctl.op = DOP_LIM;
            S_RD, S_LRD: rd_en = 1'b1;
            S_SQX:  dist_ctl.op = DOP_X;
            S_SQY:  dist_ctl.op = DOP_Y;
            S_CMP:  wr_en = r_in.cmd && hit;
            S_OBS_END: begin
                wr_en        = (r_count < CW'(CAPACITY));
                wr_addr      = r_count[AW-1:0];
                wr_data.side = r_in.side;
                wr_data.x    = r_in.obs_x;
                wr_data.y    = r_in.obs_y;
            end
            S_EMIT: begin
                push                = slot_free;
                push_beat.status    = r_status;
                push_beat.occupancy = OCC_W'(r_count);
                push_beat.last      = 1'b1;
            end
            S_LEMIT: begin
                push                 = slot_free;
                push_beat.status     = ST_LISTED;
                push_beat.entry_side = rd_data.side;
                push_beat.entry_x    = rd_data.x;
                push_beat.entry_y    = rd_data.y;
                push_beat.occupancy  = OCC_W'(r_count);
                push_beat.last       = (r_i + 1'b1 == r_count);
            end
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_i <= '0;
                    r_n <= '0;
                end
                S_CMP: begin
                    r_i <= r_i + 1'b1;
                    if (r_in.cmd && hit) r_n <= r_n + 1'b1;
                end
                S_OBS_END: if (r_count < CW'(CAPACITY)) r_count <= r_count + 1'b1;
                S_FEND: begin
                    r_count <= r_n;
                    r_i     <= '0;
                end
                S_LEMIT: if (slot_free) r_i <= r_i + 1'b1;
                default: ;
            endcase
        end
    end

    // item, limit and status registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_in <= i_in;
        if (r_state == S_LIMW) r_lim <= prod;
        if (r_state == S_SQY)  r_sqx <= prod;
        case (r_state)
            S_CMP:     r_status <= ST_DUP;
            S_OBS_END: r_status <= (r_count < CW'(CAPACITY)) ? ST_ADDED : ST_FULL;
            S_FEND:    r_status <= ST_EMPTY;
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge <= MERGE_RST;
            r_keep  <= KEEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MERGE: r_merge <= i_cfg_data;
                CFG_KEEP:  r_keep  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_out <= push_beat;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* rtl/lmmp_checker.sv */
// ----------------------------------------------------------------------------
// lmmp_checker: port-level checks of the landmark map
// Watches the handshakes and result beats of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lmmp_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  o_in_ready,
    input  wire                  o_out_valid,
    input  wire                  i_out_ready,
    input  lmmp_pkg::t_out_beat  o_out
);
    import lmmp_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // empty table beat is final and shows no entries
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_EMPTY |-> o_out.last && o_out.occupancy == '0)
        else $error("bad empty table beat");

    // observe answers are single beats
    a_obs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_ADDED || o_out.status == ST_DUP ||
                        o_out.status == ST_FULL) |-> o_out.last)
        else $error("observe answer without last");

endmodule

bind landmark_map_merge_prune lmmp_checker u_lmmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire

/* bench/landmark_map_merge_prune_tb.sv */
// ----------------------------------------------------------------------------
// landmark_map_merge_prune_tb: self-checking bench for the landmark map
// Drives observe and frame-end beats with random gaps, predicts every result
// beat with a local map model and compares each output beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module landmark_map_merge_prune_tb;
    import lmmp_pkg::*;

    localparam int CAP = 32;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_beat    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_beat   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    landmark_map_merge_prune #(.CAPACITY(CAP)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predicted map state
    t_entry       map_tab [CAP];
    int           map_count;
    logic [15:0]  merge_rad;
    logic [15:0]  keep_rad;

    t_in_beat     pending_beats [$];
    t_out_beat    expected_beats [$];
    int           error_count;
    bit           gaps_on;
    bit           stim_done;
    bit           o_in_ready_seen;

    // queue appends
    function automatic void add_pending(t_in_beat b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void add_expected(t_out_beat b);
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // squared distance, exact
    function automatic longint unsigned sq_dist(logic signed [23:0] ax,
            logic signed [23:0] ay, logic signed [23:0] bx,
            logic signed [23:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return longint'(dx * dx + dy * dy);
    endfunction

    function automatic t_out_beat mk_beat(t_status st, logic sd,
            logic signed [23:0] x, logic signed [23:0] y, logic lst);
        t_out_beat b;
        b.status     = st;
        b.entry_side = sd;
        b.entry_x    = x;
        b.entry_y    = y;
        b.occupancy  = map_count[5:0];
        b.last       = lst;
        return b;
    endfunction

    // work out the result beats of one accepted command beat
    task automatic predict_map(t_in_beat b);
        longint unsigned lim;
        bit dup;
        int n;
        dup = 0;
        if (b.cmd == 1'b0) begin
            lim = longint'(merge_rad) * longint'(merge_rad);
            for (int i = 0; i < map_count; i++)
                if (map_tab[i].side == b.side &&
                    sq_dist(b.obs_x, b.obs_y, map_tab[i].x, map_tab[i].y) < lim)
                    dup = 1;
            if (dup) begin
                add_expected(mk_beat(ST_DUP, 1'b0, 24'sd0, 24'sd0, 1'b1));
            end else if (map_count >= CAP) begin
                add_expected(mk_beat(ST_FULL, 1'b0, 24'sd0, 24'sd0, 1'b1));
            end else begin
                map_tab[map_count] = '{b.side, b.obs_x, b.obs_y};
                map_count++;
                add_expected(mk_beat(ST_ADDED, 1'b0, 24'sd0, 24'sd0, 1'b1));
            end
        end else begin
            lim = longint'(keep_rad) * longint'(keep_rad);
            n = 0;
            for (int i = 0; i < map_count; i++)
                if (sq_dist(map_tab[i].x, map_tab[i].y, b.vehicle_x,
                            b.vehicle_y) <= lim) begin
                    map_tab[n] = map_tab[i];
                    n++;
                end
            map_count = n;
            if (n == 0)
                add_expected(mk_beat(ST_EMPTY, 1'b0, 24'sd0, 24'sd0, 1'b1));
            for (int i = 0; i < n; i++)
                add_expected(mk_beat(ST_LISTED, map_tab[i].side,
                    map_tab[i].x, map_tab[i].y, i == n - 1));
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready_seen) begin
            if (pending_beats.size() > 0 && !(gaps_on && $urandom_range(99) < 12)) begin
                i_in       <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= !(gaps_on && $urandom_range(99) < 12);
    end

    // accepted beats seen at the rising edge
    always @(posedge i_clk) begin
        o_in_ready_seen <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_map(i_in);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_out_beat w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat status", o_out.status, -1);
            end else begin
                w = expected_beats.pop_front();
                if (o_out.status !== w.status)
                    report_mismatch("status", o_out.status, w.status);
                if (o_out.entry_side !== w.entry_side)
                    report_mismatch("entry_side", o_out.entry_side, w.entry_side);
                if (o_out.entry_x !== w.entry_x)
                    report_mismatch("entry_x", o_out.entry_x, w.entry_x);
                if (o_out.entry_y !== w.entry_y)
                    report_mismatch("entry_y", o_out.entry_y, w.entry_y);
                if (o_out.occupancy !== w.occupancy)
                    report_mismatch("occupancy", o_out.occupancy, w.occupancy);
                if (o_out.last !== w.last)
                    report_mismatch("last", o_out.last, w.last);
            end
        end
    end

    task automatic drain_all();
        while (pending_beats.size() > 0 || i_in_valid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_MERGE) merge_rad = val;
        else keep_rad = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_beat obs_beat(logic sd, logic signed [23:0] x,
            logic signed [23:0] y);
        t_in_beat b;
        b.cmd = 1'b0;
        b.side = sd;
        b.obs_x = x;
        b.obs_y = y;
        b.vehicle_x = 24'($urandom);
        b.vehicle_y = 24'($urandom);
        return b;
    endfunction

    function automatic t_in_beat frame_beat(logic signed [23:0] vx,
            logic signed [23:0] vy);
        t_in_beat b;
        b.cmd = 1'b1;
        b.side = 1'($urandom);
        b.obs_x = 24'($urandom);
        b.obs_y = 24'($urandom);
        b.vehicle_x = vx;
        b.vehicle_y = vy;
        return b;
    endfunction

    // random phase: clusters of landmarks near a moving vehicle, frame ends
    task automatic random_phase(int count, int spread);
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        cx = 24'($urandom);
        cy = 24'($urandom);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 15)
                add_pending(frame_beat(
                    cx + 24'($signed($urandom_range(2 * spread)) - spread),
                    cy + 24'($signed($urandom_range(2 * spread)) - spread)));
            else if ($urandom_range(99) < 8)
                add_pending(obs_beat(1'($urandom), 24'($urandom),
                                     24'($urandom)));
            else
                add_pending(obs_beat(1'($urandom),
                    cx + 24'($signed($urandom_range(2 * spread)) - spread),
                    cy + 24'($signed($urandom_range(2 * spread)) - spread)));
        end
    endtask

    initial begin
        logic signed [23:0] mx;
        logic signed [23:0] mn;
        mx = 24'h7fffff;
        mn = 24'h800000;
        error_count = 0;
        gaps_on = 1'b1;
        map_count = 0;
        merge_rad = MERGE_RST;
        keep_rad = KEEP_RST;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MERGE;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty frame end, equal distances, extremes, full table
        add_pending(frame_beat(24'sd0, 24'sd0));
        add_pending(obs_beat(1'b0, 24'sd0, 24'sd0));
        add_pending(obs_beat(1'b0, 24'sd128, 24'sd0));
        add_pending(obs_beat(1'b0, 24'sd127, 24'sd0));
        add_pending(obs_beat(1'b1, 24'sd0, 24'sd0));
        add_pending(obs_beat(1'b1, mx, mx));
        add_pending(obs_beat(1'b0, mn, mn));
        add_pending(frame_beat(mn, mn));
        add_pending(frame_beat(24'sd2560, 24'sd0));
        add_pending(frame_beat(24'sd2561, 24'sd0));
        drain_all();

        write_reg(CFG_MERGE, 16'hffff);
        write_reg(CFG_KEEP, 16'hffff);
        add_pending(obs_beat(1'b0, mx, mx));
        add_pending(obs_beat(1'b0, mn, mn));
        add_pending(frame_beat(mx, mx));
        drain_all();
        write_reg(CFG_MERGE, 16'd0);
        write_reg(CFG_KEEP, 16'd0);
        for (int i = 0; i < 34; i++)
            add_pending(obs_beat(i[0], 24'sd0, 24'sd0));
        add_pending(frame_beat(24'sd0, 24'sd0));
        add_pending(frame_beat(24'sd1, 24'sd0));
        drain_all();

        // random phases over several radius settings
        write_reg(CFG_MERGE, 16'd128);
        write_reg(CFG_KEEP, 16'd2560);
        random_phase(120, 3000);
        drain_all();
        gaps_on = 1'b0;
        write_reg(CFG_MERGE, 16'($urandom_range(1, 600)));
        write_reg(CFG_KEEP, 16'($urandom_range(1000, 9000)));
        random_phase(120, 4000);
        drain_all();
        gaps_on = 1'b1;
        write_reg(CFG_MERGE, 16'd4000);
        write_reg(CFG_KEEP, 16'hffff);
        random_phase(150, 60000);
        drain_all();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
